// File: hdl/swrs_pkg.sv
// Shared types and constants for the sector window read splitter.
// No dependencies; every other file of the block imports this package.
package swrs_pkg;

    // Fixed field widths
    localparam int REQ_W       = 16;
    localparam int POS_W       = 31;
    localparam int ADDR_W      = 32;
    localparam int DEV_LEN_W   = 15;
    localparam int STAGE_OFF_W = 9;
    localparam int COPY_LEN_W  = 15;
    localparam int DEST_OFF_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;

    // At most this many descriptors per read
    localparam int CHUNK_BUDGET = 5;
    localparam int CNT_W        = $clog2(CHUNK_BUDGET + 1);

    // Request function codes
    localparam logic FUNC_READ = 1'b0;
    localparam logic FUNC_SEEK = 1'b1;

    // Seek origin codes
    localparam logic [1:0] WHENCE_SET = 2'd0;
    localparam logic [1:0] WHENCE_CUR = 2'd1;
    localparam logic [1:0] WHENCE_END = 2'd2;
    localparam logic [1:0] WHENCE_BAD = 2'd3;

    // Result kinds
    localparam logic KIND_CHUNK = 1'b0;
    localparam logic KIND_FIN   = 1'b1;

    // Completion status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_NOT_OPEN   = 2'd1;
    localparam status_t ST_MISALIGNED = 2'd2;
    localparam status_t ST_BAD_WHENCE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    setup;
        logic    seek;
        logic    calc_len;
        logic    emit_chunk;
        logic    emit_fin;
        status_t fin_status;
    } swrs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic win_open;
        logic is_seek;
        logic misaligned;
        logic bad_whence;
        logic rem_zero;
        logic stall;
        logic out_free;
    } swrs_stat_t;

    // One result transaction
    typedef struct packed {
        logic                   kind;
        status_t                status;
        logic [ADDR_W-1:0]      dev_offset;
        logic [DEV_LEN_W-1:0]   dev_length;
        logic [STAGE_OFF_W-1:0] stage_offset;
        logic [COPY_LEN_W-1:0]  copy_length;
        logic [DEST_OFF_W-1:0]  dest_offset;
        logic [POS_W-1:0]       byte_count;
        logic                   last;
    } swrs_res_t;

endpackage

// File: hdl/swrs_if.sv
// Channel interfaces of the sector window read splitter: request, result, config.
// Depends on swrs_pkg for field widths.
interface swrs_req_if import swrs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [REQ_W-1:0]        request_size;
    logic [1:0]              dest_align;
    logic signed [ADDR_W-1:0] seek_offset;
    logic [1:0]              seek_whence;

    modport source (output valid, func, request_size, dest_align, seek_offset,
                    seek_whence, input ready);
    modport sink (input valid, func, request_size, dest_align, seek_offset,
                  seek_whence, output ready);
endinterface

interface swrs_res_if import swrs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [1:0]             status;
    logic [ADDR_W-1:0]      dev_offset;
    logic [DEV_LEN_W-1:0]   dev_length;
    logic [STAGE_OFF_W-1:0] stage_offset;
    logic [COPY_LEN_W-1:0]  copy_length;
    logic [DEST_OFF_W-1:0]  dest_offset;
    logic [POS_W-1:0]       byte_count;
    logic                   last;

    modport source (output valid, kind, status, dev_offset, dev_length, stage_offset,
                    copy_length, dest_offset, byte_count, last, input ready);
    modport sink (input valid, kind, status, dev_offset, dev_length, stage_offset,
                  copy_length, dest_offset, byte_count, last, output ready);
endinterface

interface swrs_cfg_if import swrs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/swrs_dpath.sv
// Datapath: window registers, position, chunk arithmetic and the result register.
// Depends on swrs_pkg; driven by swrs_ctrl through swrs_cmd_t.
module swrs_dpath import swrs_pkg::*; #(
    parameter int SECTOR_BYTES  = 512,
    parameter int STAGING_BYTES = 16384,
    parameter int MAX_REQUEST   = 65535
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration writes
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // request fields
    input  logic                    in_func,
    input  logic [REQ_W-1:0]        in_request_size,
    input  logic [1:0]              in_dest_align,
    input  logic signed [ADDR_W-1:0] in_seek_offset,
    input  logic [1:0]              in_seek_whence,
    // control
    input  swrs_cmd_t               cmd,
    output swrs_stat_t              stat,
    // result register
    output logic                    res_valid,
    output swrs_res_t               res_data,
    input  logic                    res_ready
);

    localparam int SEC_LOG = $clog2(SECTOR_BYTES);
    localparam int LEN_W   = $clog2(STAGING_BYTES + 1);
    localparam int GUARD_W = $clog2((2 ** REQ_W) + 3 * SECTOR_BYTES);
    localparam int SUM_W   = ADDR_W + 2;

    // window registers and position
    logic                    open_reg;
    logic [POS_W-1:0]        base_reg;
    logic [POS_W-1:0]        size_reg;
    logic [POS_W-1:0]        cur_reg, cur_next;

    // latched request
    logic                    func_reg;
    logic [REQ_W-1:0]        req_reg;
    logic [1:0]              align_reg;
    logic signed [ADDR_W-1:0] off_reg;
    logic [1:0]              whence_reg;

    // read loop state
    logic [ADDR_W-1:0]       pos_reg, wend_reg;
    logic [REQ_W-1:0]        rem_reg, moved_reg;
    logic [LEN_W-1:0]        len_reg;

    // result register
    logic                    res_valid_reg;
    swrs_res_t               res_reg, res_next;

    logic [POS_W-1:0]        win_avail;
    logic [REQ_W-1:0]        req_clip, rem_set;
    logic [SEC_LOG-1:0]      sec_off;
    logic [ADDR_W-1:0]       chunk_base, len_raw;
    logic [GUARD_W-1:0]      guard, capped, rounded;
    logic [LEN_W-1:0]        len_calc, avail;
    logic [REQ_W-1:0]        copy;
    logic [POS_W-1:0]        rel;
    logic signed [SUM_W-1:0] seek_sum;
    logic [POS_W-1:0]        seek_pos;
    logic [POS_W-1:0]        fin_count;
    logic                    out_free;

    // Read setup: bytes left in window, clipped request
    always_comb
    begin
        win_avail = (cur_reg >= size_reg) ? '0 : size_reg - cur_reg;
        req_clip  = (32'(req_reg) > 32'(MAX_REQUEST)) ? REQ_W'(MAX_REQUEST) : req_reg;
        rem_set   = (32'(req_clip) < 32'(win_avail)) ? req_clip : REQ_W'(win_avail);
    end

    // Chunk length: min(window end, guard), round to sector, cap at staging size
    always_comb
    begin
        sec_off    = pos_reg[SEC_LOG-1:0];
        chunk_base = {pos_reg[ADDR_W-1:SEC_LOG], {SEC_LOG{1'b0}}};
        len_raw    = wend_reg - chunk_base;
        guard      = GUARD_W'(rem_reg) + GUARD_W'(2 * SECTOR_BYTES);
        capped     = (len_raw < ADDR_W'(guard)) ? GUARD_W'(len_raw) : guard;
        rounded    = (capped + GUARD_W'(SECTOR_BYTES - 1)) & ~GUARD_W'(SECTOR_BYTES - 1);
        len_calc   = (32'(rounded) > 32'(STAGING_BYTES)) ? LEN_W'(STAGING_BYTES)
                                                         : LEN_W'(rounded);
    end

    // Copy length of the current chunk
    always_comb
    begin
        avail = len_reg - LEN_W'(sec_off);
        copy  = (32'(avail) > 32'(rem_reg)) ? rem_reg : REQ_W'(avail);
    end

    // Seek target, clamped to 0..size
    always_comb
    begin
        case (whence_reg)
            WHENCE_CUR: rel = cur_reg;
            WHENCE_END: rel = size_reg;
            default:    rel = '0;
        endcase
        seek_sum = SUM_W'(off_reg) + $signed({3'b000, rel});
        if (seek_sum > $signed({3'b000, size_reg}))
            seek_pos = size_reg;
        else if (seek_sum[SUM_W-1])
            seek_pos = '0;
        else
            seek_pos = seek_sum[POS_W-1:0];
    end

    // Completion count: bytes moved, new position, or zero on error
    always_comb
    begin
        if (cmd.fin_status != ST_OK)
            fin_count = '0;
        else if (func_reg == FUNC_SEEK)
            fin_count = cur_reg;
        else
            fin_count = POS_W'(moved_reg);
    end

    // Position update
    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.seek)
            cur_next = seek_pos;
        else if (cmd.emit_fin && cmd.fin_status == ST_OK && func_reg == FUNC_READ)
            cur_next = POS_W'(cur_reg + POS_W'(moved_reg));
    end

    // Next result transaction
    always_comb
    begin
        res_next = '0;
        if (cmd.emit_chunk)
        begin
            res_next.kind         = KIND_CHUNK;
            res_next.status       = ST_OK;
            res_next.dev_offset   = chunk_base;
            res_next.dev_length   = DEV_LEN_W'(len_reg);
            res_next.stage_offset = STAGE_OFF_W'(sec_off);
            res_next.copy_length  = COPY_LEN_W'(copy);
            res_next.dest_offset  = DEST_OFF_W'(moved_reg);
        end
        else
        begin
            res_next.kind       = KIND_FIN;
            res_next.status     = cmd.fin_status;
            res_next.byte_count = fin_count;
            res_next.last       = 1'b1;
        end
    end

    assign out_free = !res_valid_reg || res_ready;

    // Control state: window registers, position, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            base_reg      <= '0;
            size_reg      <= '0;
            cur_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OPEN: open_reg <= cfg_data[0];
                    CFG_BASE: base_reg <= cfg_data;
                    CFG_SIZE: size_reg <= cfg_data;
                    default:  ;
                endcase
            end
            cur_reg <= cur_next;
            if (cmd.emit_chunk || cmd.emit_fin)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload: latched request, loop registers, result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= in_func;
            req_reg    <= in_request_size;
            align_reg  <= in_dest_align;
            off_reg    <= in_seek_offset;
            whence_reg <= in_seek_whence;
        end
        if (cmd.setup)
        begin
            pos_reg   <= ADDR_W'(base_reg) + ADDR_W'(cur_reg);
            wend_reg  <= ADDR_W'(base_reg) + ADDR_W'(size_reg);
            rem_reg   <= rem_set;
            moved_reg <= '0;
        end
        if (cmd.calc_len)
            len_reg <= len_calc;
        if (cmd.emit_chunk)
        begin
            pos_reg   <= pos_reg + ADDR_W'(copy);
            moved_reg <= moved_reg + copy;
            rem_reg   <= rem_reg - copy;
        end
        if (cmd.emit_chunk || cmd.emit_fin)
            res_reg <= res_next;
    end

    // Status to the controller
    always_comb
    begin
        stat.win_open   = open_reg;
        stat.is_seek    = (func_reg == FUNC_SEEK);
        stat.misaligned = (align_reg != 2'b00);
        stat.bad_whence = (whence_reg == WHENCE_BAD);
        stat.rem_zero   = (rem_reg == '0);
        stat.stall      = (len_reg <= LEN_W'(sec_off));
        stat.out_free   = out_free;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// File: hdl/swrs_ctrl.sv
// Controller: sequences one request through decode, chunk loop and completion.
// Depends on swrs_pkg; commands swrs_dpath, reads its status.
module swrs_ctrl import swrs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  swrs_stat_t stat,
    output swrs_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_LEN,
        S_EMIT,
        S_FIN
    } state_t;

    state_t             state_reg, state_next;
    status_t            fin_status_reg, fin_status_next;
    logic [CNT_W-1:0]   chunk_cnt_reg, chunk_cnt_next;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        fin_status_next = fin_status_reg;
        chunk_cnt_next  = chunk_cnt_reg;
        cmd             = '0;
        cmd.fin_status  = fin_status_reg;
        in_ready        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next      = S_FIN;
                fin_status_next = ST_OK;
                if (!stat.win_open)
                    fin_status_next = ST_NOT_OPEN;
                else if (stat.is_seek)
                begin
                    if (stat.bad_whence)
                        fin_status_next = ST_BAD_WHENCE;
                    else
                        cmd.seek = 1'b1;
                end
                else if (stat.misaligned)
                    fin_status_next = ST_MISALIGNED;
                else
                begin
                    cmd.setup      = 1'b1;
                    chunk_cnt_next = '0;
                    state_next     = S_LEN;
                end
            end
            S_LEN:
            begin
                // stop when nothing is left or the budget is spent
                if (stat.rem_zero || chunk_cnt_reg == CNT_W'(CHUNK_BUDGET))
                    state_next = S_FIN;
                else
                begin
                    cmd.calc_len = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // a chunk that copies nothing ends the read
                if (stat.stall)
                    state_next = S_FIN;
                else if (stat.out_free)
                begin
                    cmd.emit_chunk = 1'b1;
                    chunk_cnt_next = chunk_cnt_reg + CNT_W'(1);
                    state_next     = S_LEN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_fin = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state, completion status and chunk count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fin_status_reg <= ST_OK;
            chunk_cnt_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fin_status_reg <= fin_status_next;
            chunk_cnt_reg  <= chunk_cnt_next;
        end
    end

endmodule

// File: hdl/sector_window_read_splitter.sv
// A request transaction (read or seek) is taken only while the block is idle. A seek, or a
// request refused for a closed window, misaligned destination or bad origin, gives one
// completion after the decide and finish states. A read gives one descriptor per sector-aligned
// device read, at most 5, then a completion; each chunk is first sized in the length state,
// then loaded into the result register in the emit state. Stalls on the result channel hold
// the controller in its emit or finish state. SECTOR_BYTES must be a power of two.
// Configuration writes are always ready and must be made while no request is in flight.
module sector_window_read_splitter import swrs_pkg::*; #(
    parameter int SECTOR_BYTES  = 512,
    parameter int STAGING_BYTES = 16384,
    parameter int MAX_REQUEST   = 65535
) (
    input  logic       clk,
    input  logic       rst_n,
    swrs_req_if.sink   req,
    swrs_res_if.source res,
    swrs_cfg_if.sink   cfg
);

    swrs_cmd_t  cmd;
    swrs_stat_t stat;
    swrs_res_t  res_data;
    logic       req_ready;
    logic       res_valid;

    // Configuration is accepted every cycle
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    swrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swrs_dpath #(
        .SECTOR_BYTES  (SECTOR_BYTES),
        .STAGING_BYTES (STAGING_BYTES),
        .MAX_REQUEST   (MAX_REQUEST)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .in_func         (req.func),
        .in_request_size (req.request_size),
        .in_dest_align   (req.dest_align),
        .in_seek_offset  (req.seek_offset),
        .in_seek_whence  (req.seek_whence),
        .cmd             (cmd),
        .stat            (stat),
        .res_valid       (res_valid),
        .res_data        (res_data),
        .res_ready       (res.ready)
    );

    // Drive the result channel from the result register
    assign res.valid        = res_valid;
    assign res.kind         = res_data.kind;
    assign res.status       = res_data.status;
    assign res.dev_offset   = res_data.dev_offset;
    assign res.dev_length   = res_data.dev_length;
    assign res.stage_offset = res_data.stage_offset;
    assign res.copy_length  = res_data.copy_length;
    assign res.dest_offset  = res_data.dest_offset;
    assign res.byte_count   = res_data.byte_count;
    assign res.last         = res_data.last;

`ifndef SYNTHESIS
    // Never overwrite a result transaction that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_chunk || cmd.emit_fin) |-> (!res_valid || res.ready))
        else $error("result register overwritten while pending");

    // One request at a time: no new transaction right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while previous one in flight");

    // A failed request reports no bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == KIND_FIN && res.status != ST_OK) |-> res.byte_count == '0)
        else $error("error completion with nonzero byte count");

    // Descriptors never end a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == KIND_CHUNK) |-> !res.last)
        else $error("chunk descriptor marked last");
`endif

endmodule
